// File: hdl/hch_pkg.sv
// shared types, constants and fixed-point helpers for the cubic hermite coefficient block
`timescale 1ns / 1ps
package hch_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WIDEN_SHIFT = 32 - FRAC_BITS;
	localparam int DIV_STEPS = 64;

	typedef logic signed [63:0] q_t;

	localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		q_t   val;
		logic ov;
	} res_t;

	typedef struct packed {
		q_t   xa;
		q_t   xb;
		q_t   ya;
		q_t   sa;
		q_t   sb;
		q_t   span;
		q_t   chord;
		q_t   q2;
		q_t   k3;
		q_t   t2;
		q_t   u;
		q_t   k2;
		q_t   k1a;
		q_t   w;
		q_t   k0a;
		q_t   t;
		q_t   xx;
		logic ov;
		logic zero;
	} ctx_t;

	function automatic q_t widen(input logic signed [31:0] raw);
		q_t v;
		v = 64'(raw);
		return v <<< WIDEN_SHIFT;
	endfunction

	function automatic logic [63:0] magnitude(input q_t a);
		return a[63] ? (64'd0 - 64'(a)) : 64'(a);
	endfunction

	function automatic res_t pack(input logic neg, input logic [63:0] mag, input logic sat);
		res_t r;
		r.ov = 1'b0;
		r.val = '0;
		if (sat) begin
			r.ov = 1'b1;
			r.val = neg ? Q_MIN : Q_MAX;
		end else if (neg) begin
			if (mag > 64'h8000_0000_0000_0000) begin
				r.ov = 1'b1;
				r.val = Q_MIN;
			end else begin
				r.val = q_t'(64'd0 - mag);
			end
		end else if (mag[63]) begin
			r.ov = 1'b1;
			r.val = Q_MAX;
		end else begin
			r.val = q_t'(mag);
		end
		return r;
	endfunction

	function automatic res_t sat_add(input q_t a, input q_t b);
		res_t r;
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		r.ov = s[64] != s[63];
		r.val = r.ov ? (s[64] ? Q_MIN : Q_MAX) : q_t'(s[63:0]);
		return r;
	endfunction

	function automatic res_t sat_sub(input q_t a, input q_t b);
		res_t r;
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		r.ov = s[64] != s[63];
		r.val = r.ov ? (s[64] ? Q_MIN : Q_MAX) : q_t'(s[63:0]);
		return r;
	endfunction

endpackage

// File: hdl/cubic_hermite_coefficients.sv
// Cubic Hermite segment setup: power-basis coefficients K0..K3 from two points and two
// end slopes. Inputs are signed Q16.16, results signed Q32.32 with saturation. Each item
// passes from input transfer to result through three chained dividers (68 stages each,
// one quotient bit per step stage) and three multiplier groups (5 stages each); a new
// item is taken every cycle while the output is not stalled. The whole pipeline stalls
// together while a finished result waits at the output. The user writes relative_slopes
// through cfg_we/cfg_wdata only while the block is empty; the block does not enforce it.
`timescale 1ns / 1ps
module cubic_hermite_coefficients (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] first_slope,
	input  logic signed [31:0] second_slope,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] coef_const,
	output logic signed [63:0] coef_linear,
	output logic signed [63:0] coef_square,
	output logic signed [63:0] coef_cube,
	output logic               overflow_flag,
	output logic               zero_span_flag
);

	logic en;
	logic relative_slopes_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	hch_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;
	hch_pkg::ctx_t ctx_n1, ctx_n2, ctx_n3, ctx_n4, ctx_n5, ctx_n6;
	hch_pkg::q_t dy_s1, nq_s3, nr_s3, nk_s4;
	hch_pkg::q_t dy_n1, nq_n3, nr_n3, nk_n4;
	hch_pkg::q_t k0_s7, k1_s7, k2_s7, k3_s7;
	logic ov_s7, zero_s7;

	logic d1_v, m1_v, d2_v, d3_v, m2_v, m3_v;
	hch_pkg::ctx_t d1_ctx, m1_ctx, d2_ctx, d3_ctx, m2_ctx, m3_ctx;
	hch_pkg::res_t d1_q, m1a_q, m1b_q, d2a_q, d2b_q, d3_q;
	hch_pkg::res_t m2a_q, m2b_q, m2c_q, m2d_q, m2e_q, m2f_q, m3g_q, m3h_q;

	assign en       = !v_s7 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relative_slopes_q <= 1'b0;
		end else if (cfg_we) begin
			relative_slopes_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= d1_v;
			v_s3 <= m1_v;
			v_s4 <= d2_v;
			v_s5 <= d3_v;
			v_s6 <= m2_v;
			v_s7 <= m3_v;
		end
	end

	// input widening, span and fixed sums
	always_comb begin
		hch_pkg::res_t ra, rb, rc, rd;
		ctx_n1      = '0;
		ctx_n1.xa   = hch_pkg::widen(first_x);
		ctx_n1.ya   = hch_pkg::widen(first_y);
		ctx_n1.xb   = hch_pkg::widen(second_x);
		ctx_n1.sa   = hch_pkg::widen(first_slope);
		ctx_n1.sb   = hch_pkg::widen(second_slope);
		ctx_n1.span = ctx_n1.xb - ctx_n1.xa;
		ctx_n1.zero = first_x == second_x;
		dy_n1       = ctx_n1.sb - ctx_n1.sb + hch_pkg::widen(second_y) - ctx_n1.ya;
		ra          = hch_pkg::sat_add(ctx_n1.xa, ctx_n1.xa);
		rb          = hch_pkg::sat_add(ra.val, ctx_n1.xb);
		rc          = hch_pkg::sat_add(ctx_n1.xb, ctx_n1.xb);
		rd          = hch_pkg::sat_add(ctx_n1.xa, rc.val);
		ctx_n1.t2   = rb.val;
		ctx_n1.u    = rd.val;
		ctx_n1.ov   = ra.ov || rb.ov || rc.ov || rd.ov;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_n1;
			dy_s1  <= dy_n1;
		end
	end

	hch_div u_div_chord (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s1), .a(dy_s1), .b(ctx_s1.span),
		.ctx_i(ctx_s1), .v_o(d1_v), .ctx_o(d1_ctx), .q(d1_q)
	);

	always_comb begin
		ctx_n2       = d1_ctx;
		ctx_n2.chord = d1_q.val;
		ctx_n2.ov    = d1_ctx.ov || d1_q.ov;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_n2;
		end
	end

	hch_mul u_mul_sa (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s2), .a(ctx_s2.sa), .b(ctx_s2.chord),
		.ctx_i(ctx_s2), .v_o(m1_v), .ctx_o(m1_ctx), .q(m1a_q)
	);

	hch_mul u_mul_sb (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s2), .a(ctx_s2.sb), .b(ctx_s2.chord),
		.ctx_i(ctx_s2), .v_o(), .ctx_o(), .q(m1b_q)
	);

	// optional slope scaling and second divided differences
	always_comb begin
		hch_pkg::res_t rq, rr;
		ctx_n3 = m1_ctx;
		if (relative_slopes_q) begin
			ctx_n3.sa = m1a_q.val;
			ctx_n3.sb = m1b_q.val;
			ctx_n3.ov = m1_ctx.ov || m1a_q.ov || m1b_q.ov;
		end
		rq        = hch_pkg::sat_sub(ctx_n3.chord, ctx_n3.sa);
		rr        = hch_pkg::sat_sub(ctx_n3.sb, ctx_n3.chord);
		nq_n3     = rq.val;
		nr_n3     = rr.val;
		ctx_n3.ov = ctx_n3.ov || rq.ov || rr.ov;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_n3;
			nq_s3  <= nq_n3;
			nr_s3  <= nr_n3;
		end
	end

	hch_div u_div_q2 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s3), .a(nq_s3), .b(ctx_s3.span),
		.ctx_i(ctx_s3), .v_o(d2_v), .ctx_o(d2_ctx), .q(d2a_q)
	);

	hch_div u_div_r2 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s3), .a(nr_s3), .b(ctx_s3.span),
		.ctx_i(ctx_s3), .v_o(), .ctx_o(), .q(d2b_q)
	);

	always_comb begin
		hch_pkg::res_t rk;
		ctx_n4    = d2_ctx;
		ctx_n4.q2 = d2a_q.val;
		rk        = hch_pkg::sat_sub(d2b_q.val, d2a_q.val);
		nk_n4     = rk.val;
		ctx_n4.ov = d2_ctx.ov || d2a_q.ov || d2b_q.ov || rk.ov;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_n4;
			nk_s4  <= nk_n4;
		end
	end

	hch_div u_div_k3 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s4), .a(nk_s4), .b(ctx_s4.span),
		.ctx_i(ctx_s4), .v_o(d3_v), .ctx_o(d3_ctx), .q(d3_q)
	);

	always_comb begin
		ctx_n5    = d3_ctx;
		ctx_n5.k3 = d3_q.val;
		ctx_n5.ov = d3_ctx.ov || d3_q.ov;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5 <= ctx_n5;
		end
	end

	hch_mul u_mul_k3t2 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s5), .a(ctx_s5.k3), .b(ctx_s5.t2),
		.ctx_i(ctx_s5), .v_o(m2_v), .ctx_o(m2_ctx), .q(m2a_q)
	);

	hch_mul u_mul_q2xa (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s5), .a(ctx_s5.q2), .b(ctx_s5.xa),
		.ctx_i(ctx_s5), .v_o(), .ctx_o(), .q(m2b_q)
	);

	hch_mul u_mul_xau (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s5), .a(ctx_s5.xa), .b(ctx_s5.u),
		.ctx_i(ctx_s5), .v_o(), .ctx_o(), .q(m2c_q)
	);

	hch_mul u_mul_saxa (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s5), .a(ctx_s5.sa), .b(ctx_s5.xa),
		.ctx_i(ctx_s5), .v_o(), .ctx_o(), .q(m2d_q)
	);

	hch_mul u_mul_xaxa (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s5), .a(ctx_s5.xa), .b(ctx_s5.xa),
		.ctx_i(ctx_s5), .v_o(), .ctx_o(), .q(m2e_q)
	);

	hch_mul u_mul_k3xb (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s5), .a(ctx_s5.k3), .b(ctx_s5.xb),
		.ctx_i(ctx_s5), .v_o(), .ctx_o(), .q(m2f_q)
	);

	always_comb begin
		hch_pkg::res_t r2, rd, r1, rw, r0;
		ctx_n6     = m2_ctx;
		r2         = hch_pkg::sat_sub(m2_ctx.q2, m2a_q.val);
		rd         = hch_pkg::sat_add(m2b_q.val, m2b_q.val);
		r1         = hch_pkg::sat_sub(m2_ctx.sa, rd.val);
		rw         = hch_pkg::sat_sub(m2_ctx.q2, m2f_q.val);
		r0         = hch_pkg::sat_sub(m2_ctx.ya, m2d_q.val);
		ctx_n6.k2  = r2.val;
		ctx_n6.k1a = r1.val;
		ctx_n6.w   = rw.val;
		ctx_n6.k0a = r0.val;
		ctx_n6.t   = m2c_q.val;
		ctx_n6.xx  = m2e_q.val;
		ctx_n6.ov  = m2_ctx.ov || m2a_q.ov || m2b_q.ov || m2c_q.ov || m2d_q.ov
			|| m2e_q.ov || m2f_q.ov || r2.ov || rd.ov || r1.ov || rw.ov || r0.ov;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s6 <= ctx_n6;
		end
	end

	hch_mul u_mul_k3t (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s6), .a(ctx_s6.k3), .b(ctx_s6.t),
		.ctx_i(ctx_s6), .v_o(m3_v), .ctx_o(m3_ctx), .q(m3g_q)
	);

	hch_mul u_mul_xxw (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s6), .a(ctx_s6.xx), .b(ctx_s6.w),
		.ctx_i(ctx_s6), .v_o(), .ctx_o(), .q(m3h_q)
	);

	// output register, zero span forces zero coefficients
	always_ff @(posedge clk) begin
		hch_pkg::res_t r1, r0;
		if (en) begin
			r1 = hch_pkg::sat_add(m3_ctx.k1a, m3g_q.val);
			r0 = hch_pkg::sat_add(m3_ctx.k0a, m3h_q.val);
			zero_s7 <= m3_ctx.zero;
			if (m3_ctx.zero) begin
				k0_s7 <= '0;
				k1_s7 <= '0;
				k2_s7 <= '0;
				k3_s7 <= '0;
				ov_s7 <= 1'b0;
			end else begin
				k0_s7 <= r0.val;
				k1_s7 <= r1.val;
				k2_s7 <= m3_ctx.k2;
				k3_s7 <= m3_ctx.k3;
				ov_s7 <= m3_ctx.ov || m3g_q.ov || m3h_q.ov || r1.ov || r0.ov;
			end
		end
	end

	assign out_valid      = v_s7;
	assign coef_const     = k0_s7;
	assign coef_linear    = k1_s7;
	assign coef_square    = k2_s7;
	assign coef_cube      = k3_s7;
	assign overflow_flag  = ov_s7;
	assign zero_span_flag = zero_s7;

`ifndef SYNTH
	a_zero_span_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_span_flag |-> coef_const == 64'sd0 && coef_linear == 64'sd0
			&& coef_square == 64'sd0 && coef_cube == 64'sd0 && !overflow_flag)
		else $error("zero span result not cleared");

	a_zero_matches_span: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ctx_s1.zero == (ctx_s1.span == 64'sd0))
		else $error("zero span flag disagrees with span");

	a_input_sums_exact: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !ctx_s1.ov)
		else $error("overflow in widened input sums");

	a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transfer missing from first stage");
`endif

endmodule

// File: hdl/hch_mul.sv
// pipelined q32.32 multiplier with rounding and saturation
`timescale 1ns / 1ps
module hch_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  hch_pkg::q_t   a,
	input  hch_pkg::q_t   b,
	input  hch_pkg::ctx_t ctx_i,
	output logic          v_o,
	output hch_pkg::ctx_t ctx_o,
	output hch_pkg::res_t q
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0] ua_s1, ub_s1;
	logic [63:0] ll_s2, lh_s2, hl_s2, hh_s2;
	logic [63:0] ll_s3, hh_s3;
	logic [64:0] mid_s3;
	logic [127:0] r_s4;
	hch_pkg::res_t q_s5;
	hch_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[63] ^ b[63];
			ua_s1  <= hch_pkg::magnitude(a);
			ub_s1  <= hch_pkg::magnitude(b);
			ctx_s1 <= ctx_i;

			ll_s2  <= ua_s1[31:0] * ub_s1[31:0];
			lh_s2  <= ua_s1[31:0] * ub_s1[63:32];
			hl_s2  <= ua_s1[63:32] * ub_s1[31:0];
			hh_s2  <= ua_s1[63:32] * ub_s1[63:32];
			neg_s2 <= neg_s1;
			ctx_s2 <= ctx_s1;

			mid_s3 <= {1'b0, lh_s2} + {1'b0, hl_s2};
			ll_s3  <= ll_s2;
			hh_s3  <= hh_s2;
			neg_s3 <= neg_s2;
			ctx_s3 <= ctx_s2;

			r_s4   <= {hh_s3, ll_s3} + {31'd0, mid_s3, 32'd0} + 128'h8000_0000;
			neg_s4 <= neg_s3;
			ctx_s4 <= ctx_s3;

			q_s5   <= hch_pkg::pack(neg_s4, r_s4[95:32], r_s4[127:96] != 32'd0);
			ctx_s5 <= ctx_s4;
		end
	end

	assign v_o   = v_s5;
	assign ctx_o = ctx_s5;
	assign q     = q_s5;

endmodule

// File: hdl/hch_div.sv
// pipelined q32.32 divider, one quotient bit per step stage, rounding and saturation
`timescale 1ns / 1ps
module hch_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  hch_pkg::q_t   a,
	input  hch_pkg::q_t   b,
	input  hch_pkg::ctx_t ctx_i,
	output logic          v_o,
	output hch_pkg::ctx_t ctx_o,
	output hch_pkg::res_t q
);

	typedef struct packed {
		logic neg;
		logic bz;
		logic early;
		logic anneg;
	} dflag_t;

	logic [63:0] ua, ub;

	logic          v_s   [hch_pkg::DIV_STEPS+1];
	logic [63:0]   rem_s [hch_pkg::DIV_STEPS+1];
	logic [63:0]   quo_s [hch_pkg::DIV_STEPS+1];
	logic [63:0]   ub_s  [hch_pkg::DIV_STEPS+1];
	logic [31:0]   lo_s  [hch_pkg::DIV_STEPS+1];
	dflag_t        fl_s  [hch_pkg::DIV_STEPS+1];
	hch_pkg::ctx_t ctx_s [hch_pkg::DIV_STEPS+1];

	logic v_r1, v_r2, v_r3;
	logic rnd_r1;
	logic [63:0] quo_r1;
	logic [64:0] quo_r2;
	dflag_t fl_r1, fl_r2;
	hch_pkg::ctx_t ctx_r1, ctx_r2, ctx_r3;
	hch_pkg::res_t q_r3;

	assign ua = hch_pkg::magnitude(a);
	assign ub = hch_pkg::magnitude(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]      <= {32'd0, ua[63:32]};
			quo_s[0]      <= '0;
			ub_s[0]       <= ub;
			lo_s[0]       <= ua[31:0];
			fl_s[0].neg   <= a[63] ^ b[63];
			fl_s[0].bz    <= ub == 64'd0;
			fl_s[0].early <= {32'd0, ua[63:32]} >= ub;
			fl_s[0].anneg <= !a[63];
			ctx_s[0]      <= ctx_i;
		end
	end

	for (genvar k = 1; k <= hch_pkg::DIV_STEPS; k++) begin : g_step
		logic [64:0] r65;
		logic        ge;

		assign r65 = {rem_s[k-1], lo_s[k-1][31]};
		assign ge  = r65 >= {1'b0, ub_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? 64'(r65 - {1'b0, ub_s[k-1]}) : r65[63:0];
				quo_s[k] <= {quo_s[k-1][62:0], ge};
				ub_s[k]  <= ub_s[k-1];
				lo_s[k]  <= {lo_s[k-1][30:0], 1'b0};
				fl_s[k]  <= fl_s[k-1];
				ctx_s[k] <= ctx_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0;
			v_r2 <= 1'b0;
			v_r3 <= 1'b0;
		end else if (en) begin
			v_r1 <= v_s[hch_pkg::DIV_STEPS];
			v_r2 <= v_r1;
			v_r3 <= v_r2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_r1 <= {rem_s[hch_pkg::DIV_STEPS], 1'b0} >= {1'b0, ub_s[hch_pkg::DIV_STEPS]};
			quo_r1 <= quo_s[hch_pkg::DIV_STEPS];
			fl_r1  <= fl_s[hch_pkg::DIV_STEPS];
			ctx_r1 <= ctx_s[hch_pkg::DIV_STEPS];

			quo_r2 <= {1'b0, quo_r1} + {64'd0, rnd_r1};
			fl_r2  <= fl_r1;
			ctx_r2 <= ctx_r1;

			if (fl_r2.bz) begin
				q_r3.ov  <= 1'b1;
				q_r3.val <= fl_r2.anneg ? hch_pkg::Q_MAX : hch_pkg::Q_MIN;
			end else begin
				q_r3 <= hch_pkg::pack(fl_r2.neg, quo_r2[63:0], fl_r2.early || quo_r2[64]);
			end
			ctx_r3 <= ctx_r2;
		end
	end

	assign v_o   = v_r3;
	assign ctx_o = ctx_r3;
	assign q     = q_r3;

endmodule
